/* src/sha256_message_digest_defines.svh */
// Assertion macros shared by the digest block.
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sha_pkg.sv */
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int LenLimit   = 56;
    localparam logic [7:0] PadMark = 8'h80;

    typedef logic [31:0] t_word;
    typedef t_word [7:0] t_hash;

    typedef enum logic [1:0] {
        JOB_DATA  = 2'd0,
        JOB_FINAL = 2'd1,
        JOB_EXTRA = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [63:0] bits;
    } t_job_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_LOAD  = 3'd1,
        ST_ROUND = 3'd2,
        ST_ADD   = 3'd3,
        ST_EMIT  = 3'd4
    } t_core_state;

    localparam t_hash InitHash = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* src/sha_front.sv */
module sha_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_message_byte,
    input  logic                i_has_byte,
    input  logic                i_end_of_message,
    output logic                o_full,
    output logic                o_job_valid,
    output sha_pkg::t_job_ctrl  o_job_ctrl,
    output logic [511:0]        o_job_block,
    input  logic                i_job_ready
);

    // Block assembly: a byte register file, a fill count and the running bit length.
    // The extra padding block is queued behind the first when the length does not fit.
    // It starts with the pad mark only when the message ended exactly on a full block.
    logic [7:0]  r_buf [64];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic        r_pend_extra;
    logic [63:0] r_extra_bits;
    logic        r_extra_mark;

    logic        accept;
    logic [6:0]  fill_after;
    logic [63:0] bits_after;
    logic        emit_now;
    logic [511:0] block_now;
    logic [511:0] n_block;
    sha_pkg::t_job_ctrl n_ctrl;
    logic        n_extra;
    logic [5:0]  pad_pos;
    logic [7:0]  byte_sel [64];

    assign o_full = o_job_valid && !i_job_ready || r_pend_extra;
    assign accept = i_push && !o_full;

    always_comb begin
        fill_after = {1'b0, r_fill} + {6'd0, i_has_byte};
        bits_after = r_bits + (i_has_byte ? 64'd8 : 64'd0);
        pad_pos    = fill_after[5:0];
        emit_now   = 1'b0;
        n_extra    = 1'b0;
        n_ctrl.kind = sha_pkg::JOB_DATA;
        n_ctrl.bits = bits_after;
        for (int i = 0; i < 64; i++) begin
            byte_sel[i] = (i_has_byte && i == int'(r_fill)) ? i_message_byte : r_buf[i];
        end
        if (fill_after[6]) begin
            emit_now = 1'b1;
            for (int i = 0; i < 64; i++) begin
                n_block[511 - 8 * i -: 8] = byte_sel[i];
            end
            if (i_end_of_message) begin
                n_extra = 1'b1;
            end
        end else begin
            for (int i = 0; i < 64; i++) begin
                n_block[511 - 8 * i -: 8] = byte_sel[i];
            end
            if (i_end_of_message) begin
                emit_now = 1'b1;
                for (int i = 0; i < 64; i++) begin
                    if (i == int'(pad_pos)) begin
                        n_block[511 - 8 * i -: 8] = sha_pkg::PadMark;
                    end else if (i > int'(pad_pos)) begin
                        n_block[511 - 8 * i -: 8] = 8'h00;
                    end
                end
                if (int'(pad_pos) >= sha_pkg::LenLimit) begin
                    n_extra = 1'b1;
                end else begin
                    n_ctrl.kind = sha_pkg::JOB_FINAL;
                    n_block[63:0] = bits_after;
                end
            end
        end
        block_now = n_block;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_bits       <= '0;
            r_pend_extra <= 1'b0;
            o_job_valid  <= 1'b0;
        end else begin
            if (r_pend_extra && (!o_job_valid || i_job_ready)) begin
                o_job_valid  <= 1'b1;
                r_pend_extra <= 1'b0;
            end else if (accept) begin
                if (i_has_byte) begin
                    r_buf[r_fill] <= i_message_byte;
                end
                r_fill      <= i_end_of_message ? 6'd0 : fill_after[5:0];
                r_bits      <= i_end_of_message ? 64'd0 : bits_after;
                o_job_valid <= emit_now;
                if (emit_now) begin
                    r_pend_extra <= n_extra;
                end
            end else if (o_job_valid && i_job_ready) begin
                o_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_extra && (!o_job_valid || i_job_ready)) begin
            o_job_ctrl.kind <= sha_pkg::JOB_EXTRA;
            o_job_ctrl.bits <= r_extra_bits;
            o_job_block     <= {(r_extra_mark ? sha_pkg::PadMark : 8'h00), 440'd0,
                                r_extra_bits};
        end else if (accept && emit_now) begin
            o_job_ctrl   <= n_ctrl;
            o_job_block  <= block_now;
            r_extra_bits <= bits_after;
            r_extra_mark <= fill_after[6];
        end
    end

endmodule

/* src/sha_core.sv */
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  sha_pkg::t_job_ctrl i_job_ctrl,
    input  logic [511:0]       i_job_block,
    output logic               o_job_ready,
    output logic               o_res_valid,
    output logic [31:0]        o_res_word,
    output logic [2:0]         o_res_index,
    input  logic               i_res_ready,
    output logic               o_busy
);

    sha_pkg::t_core_state r_state, n_state;
    sha_pkg::t_hash r_hash;
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word r_w [16];
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    logic        r_final;

    sha_pkg::t_word w_cur, s0, s1, t1, t2, w15, w2;

    always_comb begin
        w15 = r_w[1];
        w2  = r_w[14];
        s0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
        s1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
        w_cur = r_w[0];
        t1 = r_v[7] + (sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
             ^ sha_pkg::rotr(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha_pkg::round_k(r_round) + w_cur;
        t2 = (sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
             ^ sha_pkg::rotr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha_pkg::ST_IDLE:  if (i_job_valid) n_state = sha_pkg::ST_ROUND;
            sha_pkg::ST_LOAD:  n_state = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND: if (r_round == 6'd63) n_state = sha_pkg::ST_ADD;
            sha_pkg::ST_ADD:   n_state = r_final ? sha_pkg::ST_EMIT : sha_pkg::ST_IDLE;
            sha_pkg::ST_EMIT:  if (i_res_ready && r_idx == 3'd7) n_state = sha_pkg::ST_IDLE;
            default:           n_state = sha_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = (r_state == sha_pkg::ST_IDLE);
        o_res_valid = (r_state == sha_pkg::ST_EMIT);
        o_res_word  = r_hash[r_idx];
        o_res_index = r_idx;
        o_busy      = (r_state != sha_pkg::ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::ST_IDLE;
            r_hash  <= sha_pkg::InitHash;
            r_idx   <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                sha_pkg::ST_IDLE: begin
                    if (i_job_valid) begin
                        r_final <= (i_job_ctrl.kind != sha_pkg::JOB_DATA);
                    end
                end
                sha_pkg::ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_v[i];
                    end
                    r_idx <= '0;
                end
                sha_pkg::ST_EMIT: begin
                    if (i_res_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_hash <= sha_pkg::InitHash;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sha_pkg::ST_IDLE && i_job_valid) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_job_block[511 - 32 * i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
            r_round <= '0;
        end else if (r_state == sha_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= s1 + r_w[9] + s0 + r_w[0];
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            r_round <= r_round + 6'd1;
        end
    end

endmodule

/* src/sha256_message_digest.sv */
// Channel  | Direction | Handshake         | Payload
// request  | in        | i_push / o_full   | i_message_byte, i_has_byte, i_end_of_message
// digest   | out       | o_empty / i_pop   | o_digest_word, o_word_index, o_last_word
// Bytes are taken one per cycle while no finished block waits for the compression core.
// A block passes through the core in order: load, 64 rounds, then the hash update.
// An end request adds one or two blocks and then eight digest words.
// Reset is synchronous and active low and restores the initial hash.
// A stalled pop holds the current word; o_full holds off new bytes while a block waits.
`include "sha256_message_digest_defines.svh"
module sha256_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_message_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_full,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic               job_valid, job_ready, res_valid, busy;
    sha_pkg::t_job_ctrl job_ctrl;
    logic [511:0]       job_block;

    sha_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_message_byte  (i_message_byte),
        .i_has_byte      (i_has_byte),
        .i_end_of_message(i_end_of_message),
        .o_full          (o_full),
        .o_job_valid     (job_valid),
        .o_job_ctrl      (job_ctrl),
        .o_job_block     (job_block),
        .i_job_ready     (job_ready)
    );

    sha_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job_ctrl  (job_ctrl),
        .i_job_block (job_block),
        .o_job_ready (job_ready),
        .o_res_valid (res_valid),
        .o_res_word  (o_digest_word),
        .o_res_index (o_word_index),
        .i_res_ready (i_pop),
        .o_busy      (busy)
    );

    assign o_empty     = !res_valid;
    assign o_last_word = res_valid && (o_word_index == 3'd7);

    `SHA_ASSERT_IMPL(a_last_only_seven, i_clk, i_rst_n, o_last_word, o_word_index == 3'd7, "last flag off word seven")
    `SHA_ASSERT_IMPL(a_emit_busy, i_clk, i_rst_n, !o_empty, busy, "digest shown while core idle")
    `SHA_ASSERT_NEXT(a_index_step, i_clk, i_rst_n, !o_empty && i_pop && !o_last_word, !o_empty && o_word_index == $past(o_word_index) + 3'd1, "digest word skipped")

endmodule
